[design/timestamped_ring_log_store_macros.svh]
// Assertion macros used by the ring log store RTL.
`ifndef TIMESTAMPED_RING_LOG_STORE_MACROS_SVH
`define TIMESTAMPED_RING_LOG_STORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define TRLS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define TRLS_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

[design/trls_pkg.sv]
// Types, constants and helpers of the timestamped ring log store.
package trls_pkg;

  localparam int CAPACITY      = 1024;
  localparam int PAYLOAD_WIDTH = 32;

  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CAP_W    = 11;
  localparam int TS_W     = 64;
  localparam int OUT_PW   = 32;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_UPDATE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_WRITE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]        operation;
    logic [TS_W-1:0]   timestamp;
    logic [OUT_PW-1:0] payload;
  } req_t;

  typedef struct packed {
    logic              status;
    logic [TS_W-1:0]   found_timestamp;
    logic [OUT_PW-1:0] found_payload;
  } rsp_t;

  typedef struct packed {
    logic [TS_W-1:0]          stamp;
    logic [PAYLOAD_WIDTH-1:0] pay;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  // Clamp the capacity register to the usable ring size.
  function automatic logic [CNT_W-1:0] eff_size(input logic [CAP_W-1:0] cap);
    int c;
    c = int'(cap);
    if (c == 0) c = 1;
    if (c > CAPACITY) c = CAPACITY;
    return CNT_W'(c);
  endfunction

endpackage

[design/timestamped_ring_log_store.sv]
// Timestamped ring log store: ring of records with binary-search lookup.
// Append: read newest, compare, write, done (a reject skips the write, an empty log the
//   read and compare, a zero stamp or opcode 3 all but done); lookup and update read and
//   compare per probe until a hit or an empty range, then an update hit writes. One item at
//   a time, the next taken once the result shows; an output stall delays it; one read port.
// Reset: synchronous; empties the log, capacity 1024; only written slots are ever compared.
module timestamped_ring_log_store (
  input  logic                           clk,
  input  logic                           rst,
  // request channel
  input  logic                           req_valid,
  output logic                           req_stall,
  input  trls_pkg::req_t                 req,
  // response channel
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output trls_pkg::rsp_t                 rsp,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [trls_pkg::CFG_AW-1:0]    paddr,
  input  logic [trls_pkg::CFG_DW-1:0]    pwdata,
  output logic [trls_pkg::CFG_DW-1:0]    prdata,
  output logic                           pready
);

  import trls_pkg::*;

`include "timestamped_ring_log_store_macros.svh"

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  state_t            state;
  state_t            state_next;
  logic [CAP_W-1:0]  cap_reg;
  logic [CNT_W-1:0]  count;        // valid records in the ring
  logic [IDX_W-1:0]  oldest;       // slot of the oldest record
  logic [CNT_W-1:0]  size;         // clamped ring size

  // Item being worked on
  op_t               op;
  logic [TS_W-1:0]   ts;
  logic [OUT_PW-1:0] pl;

  // Binary search bounds, probe position and probed slot
  logic [CNT_W-1:0]  lo;
  logic [CNT_W-1:0]  hi;
  logic [CNT_W-1:0]  pos;
  logic [IDX_W-1:0]  slot;

  // Staged result, moved into the response register in ST_DONE
  logic              res_status;
  logic [TS_W-1:0]   res_stamp;
  logic [OUT_PW-1:0] res_pay;

  // RAM side
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  slot_t             ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  slot_t             ram_rdata;

  logic              req_xfer;
  logic              rsp_free;
  logic              cfg_wr;
  logic              searching;
  logic              search_done;
  logic [CNT_W-1:0]  mid;
  logic [CNT_W-1:0]  wrap_sel;
  logic [CNT_W:0]    wrap_sum;
  logic [IDX_W-1:0]  wrap_slot;
  logic [CNT_W-1:0]  oldest_inc;
  op_t               req_op;

  assign size      = eff_size(cap_reg);
  assign req_op    = op_t'(req.operation);
  assign req_xfer  = req_valid && !req_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign searching = (op == OP_LOOKUP) || (op == OP_UPDATE);
  assign search_done = (lo >= hi);
  assign mid       = lo + ((hi - lo) >> 1);

  // ---------------------------------------------------------------------------
  // Shared slot unit: logical position -> physical slot, one add and one
  // compare-subtract. The position stays below twice the ring size.
  // ---------------------------------------------------------------------------
  always_comb begin
    if (state == ST_READ) begin
      wrap_sel = searching ? mid : pos;
    end else begin
      wrap_sel = count;
    end
    wrap_sum = {1'b0, CNT_W'(oldest)} + {1'b0, wrap_sel};
    if (wrap_sum >= {1'b0, size}) begin
      wrap_slot = IDX_W'(wrap_sum - {1'b0, size});
    end else begin
      wrap_slot = IDX_W'(wrap_sum);
    end
  end

  assign oldest_inc = CNT_W'(oldest) + CNT_W'(1);

  // ---------------------------------------------------------------------------
  // Configuration port: single register, selected by paddr[2] low (byte addresses 0 to 3).
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);

  always_comb begin
    if (paddr[2] == 1'b0) begin
      prdata = CFG_DW'(cap_reg);
    end else begin
      prdata = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_xfer) begin
          case (req_op)
            OP_APPEND: begin
              if (req.timestamp == '0) begin
                state_next = ST_DONE;
              end else if (count == '0) begin
                state_next = ST_WRITE;
              end else begin
                state_next = ST_READ;
              end
            end
            OP_LOOKUP, OP_UPDATE: state_next = ST_READ;
            default:              state_next = ST_DONE;
          endcase
        end
      end
      ST_READ: begin
        // an exhausted search range is a miss
        if (searching && search_done) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_CMP;
        end
      end
      ST_CMP: begin
        if (searching) begin
          if (ram_rdata.stamp == ts) begin
            state_next = (op == OP_UPDATE) ? ST_WRITE : ST_DONE;
          end else begin
            state_next = ST_READ;
          end
        end else begin
          // append: newest record must be older than the new one
          state_next = (ts > ram_rdata.stamp) ? ST_WRITE : ST_DONE;
        end
      end
      ST_WRITE: state_next = ST_DONE;
      ST_DONE: begin
        if (rsp_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: outputs to the RAM and request channel
  // ---------------------------------------------------------------------------
  always_comb begin
    req_stall = (state != ST_IDLE);
    ram_raddr = wrap_slot;
    ram_we    = 1'b0;
    ram_waddr = wrap_slot;
    ram_wdata.stamp = ts;
    ram_wdata.pay   = '0;
    case (state)
      ST_WRITE: begin
        ram_we = 1'b1;
        if (op == OP_UPDATE) begin
          // overwrite the matched slot; its stamp equals the request stamp
          ram_waddr     = slot;
          ram_wdata.pay = PAYLOAD_WIDTH'(pl);
        end
      end
      default: ram_we = 1'b0;
    endcase
  end

  trls_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (CAPACITY)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cap_reg   <= CAP_RESET;
      count     <= '0;
      oldest    <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr) begin
        // a new capacity empties the log
        cap_reg <= CAP_W'(pwdata);
        count   <= '0;
        oldest  <= '0;
      end else if (state == ST_WRITE && op == OP_APPEND) begin
        // grow until full, then advance past the overwritten oldest record
        if (count < size) begin
          count <= count + CNT_W'(1);
        end else if (oldest_inc == size) begin
          oldest <= '0;
        end else begin
          oldest <= IDX_W'(oldest_inc);
        end
      end
      if (state == ST_DONE && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (req_xfer) begin
          op         <= req_op;
          ts         <= req.timestamp;
          pl         <= req.payload;
          lo         <= '0;
          hi         <= count;
          pos        <= count - CNT_W'(1);
          res_status <= 1'b1;
          res_stamp  <= '0;
          res_pay    <= '0;
        end
      end
      ST_READ: begin
        pos  <= mid;
        slot <= wrap_slot;
      end
      ST_CMP: begin
        if (searching) begin
          if (ram_rdata.stamp == ts) begin
            res_status <= 1'b0;
            if (op == OP_LOOKUP) begin
              res_stamp <= ram_rdata.stamp;
              res_pay   <= OUT_PW'(ram_rdata.pay);
            end
          end else if (ram_rdata.stamp < ts) begin
            lo <= pos + CNT_W'(1);
          end else begin
            hi <= pos;
          end
        end
      end
      ST_WRITE: begin
        res_status <= 1'b0;
      end
      ST_DONE: begin
        if (rsp_free) begin
          rsp.status          <= res_status;
          rsp.found_timestamp <= res_stamp;
          rsp.found_payload   <= res_pay;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `TRLS_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count <= size)
  `TRLS_ASSERT_IMP(a_oldest_bound, clk, rst, 1'b1, CNT_W'(oldest) < size)
  `TRLS_ASSERT_IMP(a_search_range, clk, rst, (state == ST_READ) && searching, lo <= hi)
  `TRLS_ASSERT_NXT(a_cmp_after_read, clk, rst, state == ST_CMP, state != ST_CMP)

endmodule

[design/trls_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module trls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[test/log_store_checker.sv]
// Checker for the ring log store: mirrors the ring, predicts each reply and compares it.
`timescale 1ns / 1ps

module log_store_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  input  logic                                req_stall,
  input  trls_pkg::req_t                      req,
  input  logic                                rsp_valid,
  input  logic                                rsp_stall,
  input  trls_pkg::rsp_t                      rsp,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic                                pready,
  input  logic [trls_pkg::CFG_AW-1:0]         paddr,
  input  logic [trls_pkg::CFG_DW-1:0]         pwdata,
  output int                                  fail_count,
  output int                                  pending
);

  localparam int CAP_REG_INDEX = 0;

  // Mirror of the ring and its bookkeeping.
  logic [trls_pkg::TS_W-1:0]          ring_time [trls_pkg::CAPACITY];
  logic [trls_pkg::PAYLOAD_WIDTH-1:0] ring_pay  [trls_pkg::CAPACITY];
  int                                 ring_head;
  int                                 ring_fill;
  logic [trls_pkg::CAP_W-1:0]         cap_reg;

  trls_pkg::rsp_t pending_replies [$];
  trls_pkg::rsp_t want;

  // Usable ring size: zero acts as one, oversize clamps to the full ring.
  function automatic int ring_size();
    int n;
    n = int'(cap_reg);
    if (n == 0) n = 1;
    if (n > trls_pkg::CAPACITY) n = trls_pkg::CAPACITY;
    return n;
  endfunction

  function automatic int ring_slot(input int pos);
    return (ring_head + pos) % ring_size();
  endfunction

  function automatic bit search_stamp(input logic [trls_pkg::TS_W-1:0] ts, output int slot);
    int lo;
    int hi;
    int mid;
    int s;
    lo = 0;
    hi = ring_fill;
    slot = 0;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      s = ring_slot(mid);
      if (ring_time[s] == ts) begin
        slot = s;
        return 1'b1;
      end
      if (ring_time[s] < ts) lo = mid + 1;
      else hi = mid;
    end
    return 1'b0;
  endfunction

  // Apply one request to the mirror and return the reply it must produce.
  function automatic trls_pkg::rsp_t apply_request(input trls_pkg::req_t item);
    trls_pkg::rsp_t r;
    int size;
    int s;
    r.status = 1'b1;
    r.found_timestamp = '0;
    r.found_payload = '0;
    size = ring_size();
    case (item.operation)
      trls_pkg::OP_APPEND: begin
        if (item.timestamp != 0 &&
            (ring_fill == 0 || item.timestamp > ring_time[ring_slot(ring_fill - 1)])) begin
          s = ring_slot(ring_fill);
          ring_time[s] = item.timestamp;
          ring_pay[s] = '0;
          // Full ring: drop the oldest record by advancing the head.
          if (ring_fill < size) ring_fill++;
          else ring_head = (ring_head + 1) % size;
          r.status = 1'b0;
        end
      end
      trls_pkg::OP_LOOKUP: begin
        if (search_stamp(item.timestamp, s)) begin
          r.status = 1'b0;
          r.found_timestamp = ring_time[s];
          r.found_payload = trls_pkg::OUT_PW'(ring_pay[s]);
        end
      end
      trls_pkg::OP_UPDATE: begin
        if (search_stamp(item.timestamp, s)) begin
          ring_pay[s] = trls_pkg::PAYLOAD_WIDTH'(item.payload);
          r.status = 1'b0;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Sample mid-cycle: every handshake signal is settled and holds until the
  // rising edge at which the transfer lands.
  always @(negedge clk) begin
    if (rst) begin
      ring_head = 0;
      ring_fill = 0;
      cap_reg = trls_pkg::CAP_RESET;
      pending_replies.delete();
      fail_count = 0;
    end else begin
      // Retire a reply first: one taken on the same edge as a request is older.
      if (rsp_valid && !rsp_stall) begin
        if (pending_replies.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected reply: status=%0d ts=%h payload=%h",
                     rsp.status, rsp.found_timestamp, rsp.found_payload);
          fail_count++;
        end else begin
          want = pending_replies.pop_front();
          if (rsp.status !== want.status || rsp.found_timestamp !== want.found_timestamp ||
              rsp.found_payload !== want.found_payload) begin
            if (fail_count < 10)
              $display("mismatch: expected st=%0d ts=%h pl=%h, got st=%0d ts=%h pl=%h",
                       want.status, want.found_timestamp, want.found_payload,
                       rsp.status, rsp.found_timestamp, rsp.found_payload);
            fail_count++;
          end
        end
      end
      if (req_valid && !req_stall)
        pending_replies.push_back(apply_request(req));
      // A capacity write also empties the log.
      if (psel && penable && pwrite && pready && int'(paddr >> 2) == CAP_REG_INDEX) begin
        cap_reg = pwdata[trls_pkg::CAP_W-1:0];
        ring_head = 0;
        ring_fill = 0;
      end
    end
    pending = pending_replies.size();
  end

endmodule

[test/testbench.sv]
// Top of the ring log store test: stimulus, stall pattern, watchdog and verdict.
`timescale 1ns / 1ps

module testbench;
  import trls_pkg::*;

  localparam logic [CFG_AW-1:0] CAP_REG_ADDR   = '0;
  localparam int                WATCHDOG_LIMIT = 4000;
  localparam int                POOL_DEPTH     = 64;
  localparam int                SETTLE_CYCLES  = 30;

  logic              clk = 1'b0;
  logic              rst;
  logic              req_valid;
  logic              req_stall;
  req_t              req;
  logic              rsp_valid;
  logic              rsp_stall = 1'b0;
  rsp_t              rsp;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  int fail_count;
  int pending;

  // Generator bookkeeping: newest accepted stamp and a pool of recent ones,
  // so that lookups and updates mostly hit records that exist.
  logic [TS_W-1:0] newest_stamp;
  logic [TS_W-1:0] phase_base;
  logic [TS_W-1:0] stamp_pool [$];
  int              burst_left = 0;
  int              stall_run = 0;
  int              idle_cycles = 0;

  always #4 clk = ~clk;

  timestamped_ring_log_store dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  log_store_checker checker_inst (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Receiver stall: short stalls, long stalls and long stretches with none.
  always @(posedge clk) begin
    if (stall_run > 0) begin
      stall_run <= stall_run - 1;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          rsp_stall <= 1'b0;
          stall_run <= $urandom_range(0, 7);
        end
        4, 5, 6: begin
          rsp_stall <= 1'b1;
          stall_run <= $urandom_range(0, 2);
        end
        7, 8: begin
          rsp_stall <= 1'b0;
          stall_run <= $urandom_range(30, 150);
        end
        default: begin
          rsp_stall <= 1'b1;
          stall_run <= $urandom_range(15, 50);
        end
      endcase
    end
  end

  // Watchdog: end the run when no transfer of any kind happens for too long.
  always @(negedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
        (psel && penable && pwrite && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Sender gap: mostly none or short, a few long, with bursts of no gaps.
  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      burst_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 82) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Build one random request, mostly well-formed against the current log.
  function automatic req_t make_request();
    req_t            item;
    int              r;
    int              q;
    logic [TS_W-1:0] anchor;
    logic [TS_W-1:0] step;
    logic [TS_W-1:0] ts;
    item.payload = $urandom;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      item.operation = OP_NONE;
      item.timestamp = {$urandom, $urandom};
    end else if (r < 43) begin
      item.operation = OP_APPEND;
      anchor = (newest_stamp == 0) ? phase_base : newest_stamp;
      q = $urandom_range(0, 99);
      if (q < 78) begin
        r = $urandom_range(0, 99);
        if (r < 80) step = TS_W'($urandom_range(1, 4));
        else if (r < 95) step = TS_W'($urandom_range(5, 1000));
        else step = {32'h0, $urandom} + 1;
        ts = anchor + step;
      end else if (q < 86) begin
        ts = newest_stamp;
      end else if (q < 91 && newest_stamp > 3) begin
        ts = newest_stamp - TS_W'($urandom_range(1, 3));
      end else if (q < 95 || newest_stamp == 0) begin
        ts = '0;
      end else begin
        ts = {$urandom, $urandom} % newest_stamp;
      end
      // Track what the log will accept: nonzero and above the newest record.
      if (ts != 0 && ts > newest_stamp) begin
        newest_stamp = ts;
        stamp_pool.push_back(ts);
        if (stamp_pool.size() > POOL_DEPTH) void'(stamp_pool.pop_front());
      end
      item.timestamp = ts;
    end else begin
      item.operation = (r < 78) ? OP_LOOKUP : OP_UPDATE;
      q = $urandom_range(0, 99);
      if (stamp_pool.size() == 0 || q < 8) begin
        ts = {$urandom, $urandom};
      end else if (q < 70) begin
        ts = stamp_pool[$urandom_range(0, stamp_pool.size() - 1)];
      end else if (q < 82) begin
        ts = stamp_pool[$urandom_range(0, stamp_pool.size() - 1)];
        ts = $urandom_range(0, 1) ? ts + 1 : ts - 1;
      end else if (q < 88) begin
        ts = '0;
      end else if (q < 94) begin
        ts = newest_stamp + TS_W'($urandom_range(1, 5));
      end else begin
        ts = {$urandom, $urandom};
      end
      item.timestamp = ts;
    end
    return item;
  endfunction

  // Offer one request and hold it until the transfer lands.
  task automatic send_request(input req_t item);
    int gap;
    bit taken;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !req_stall;
      @(posedge clk);
    end
  endtask

  task automatic send_op(input op_t op, input logic [TS_W-1:0] ts, input logic [OUT_PW-1:0] pl);
    req_t item;
    item.operation = op;
    item.timestamp = ts;
    item.payload = pl;
    send_request(item);
  endtask

  // Drop valid and hold off until every reply has come back.
  task automatic drain_replies();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Write the capacity register once the block is idle; this empties the log.
  task automatic write_capacity(input logic [CFG_DW-1:0] value);
    bit done;
    drain_replies();
    repeat (8) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CAP_REG_ADDR;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    done = 1'b0;
    while (!done) begin
      @(negedge clk);
      done = pready;
      @(posedge clk);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    newest_stamp = '0;
    stamp_pool.delete();
  endtask

  task automatic run_phase(input logic [CFG_DW-1:0] cap_word, input int count,
                           input bit pause_midway);
    write_capacity(cap_word);
    phase_base = {$urandom, $urandom} >> $urandom_range(2, 62);
    for (int i = 0; i < count; i++) begin
      if (pause_midway && i == count / 2) drain_replies();
      send_request(make_request());
    end
  endtask

  initial begin
    rst <= 1'b1;
    req_valid <= 1'b0;
    req <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    newest_stamp = '0;
    phase_base = 64'd1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset capacity: empty log, rejects, hits and misses.
    send_op(OP_LOOKUP, 64'd5, 32'h0);
    send_op(OP_UPDATE, 64'd5, 32'h1234_5678);
    send_op(OP_APPEND, 64'd0, 32'hFFFF_FFFF);
    send_op(OP_APPEND, 64'd10, 32'hFFFF_FFFF);
    send_op(OP_APPEND, 64'd10, 32'h0);
    send_op(OP_APPEND, 64'd9, 32'h0);
    send_op(OP_APPEND, 64'd20, 32'h0);
    send_op(OP_APPEND, 64'd30, 32'h0);
    send_op(OP_LOOKUP, 64'd20, 32'h0);
    send_op(OP_UPDATE, 64'd20, 32'hFFFF_FFFF);
    send_op(OP_LOOKUP, 64'd20, 32'h0);
    send_op(OP_LOOKUP, 64'd15, 32'h0);
    send_op(OP_LOOKUP, 64'd5, 32'h0);
    send_op(OP_LOOKUP, 64'd40, 32'h0);
    send_op(OP_LOOKUP, 64'd0, 32'h0);
    send_op(OP_UPDATE, 64'd0, 32'hA5A5_A5A5);
    send_op(OP_NONE, 64'd10, 32'hDEAD_BEEF);
    send_op(OP_UPDATE, 64'd10, 32'h5A5A_5A5A);
    send_op(OP_LOOKUP, 64'd10, 32'h0);
    send_op(OP_APPEND, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
    send_op(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_op(OP_APPEND, 64'd1, 32'h0);
    send_op(OP_LOOKUP, 64'd30, 32'h0);

    // Random part over several capacities, the extremes among them.
    run_phase(32'd3, 150, 1'b0);
    run_phase(32'd0, 100, 1'b0);
    run_phase(32'd1, 80, 1'b0);
    run_phase(32'd2047, 150, 1'b0);
    run_phase(32'd1025, 100, 1'b0);
    run_phase(32'd2, 120, 1'b0);
    run_phase(32'hFFFF_F805, 120, 1'b0);
    run_phase(32'd1024, 200, 1'b0);
    run_phase(32'd17, 150, 1'b1);
    run_phase(32'($urandom_range(1, 40)), 150, 1'b0);
    run_phase(32'd7, 130, 1'b0);

    drain_replies();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/trls_pkg.sv
design/trls_ram.sv
design/timestamped_ring_log_store.sv
test/log_store_checker.sv
test/testbench.sv
